// File: hdl/cis_pkg.sv
// ----------------------------------------------------------------------------
// cis_pkg: shared types, constants and microcode for the contact impulse solver
// Holds the item structs, the ALU request/response structs, the operand codes
// and the solve program that the sequencer steps through.
// ----------------------------------------------------------------------------
package cis_pkg;

	// Number format
	localparam int WORD_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int UW         = WORD_WIDTH - 1;

	typedef logic signed [WORD_WIDTH-1:0] word_t;
	typedef logic [UW-1:0]                uword_t;

	localparam word_t VMAX = word_t'({1'b0, {(WORD_WIDTH-1){1'b1}}});
	localparam word_t VMIN = word_t'({1'b1, {(WORD_WIDTH-1){1'b0}}});

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIME_STEP   = 3'd0,
		CFG_BAUMGARTE   = 3'd1,
		CFG_POS_SLOP    = 3'd2,
		CFG_RESTITUTION = 3'd3,
		CFG_VEL_SLOP    = 3'd4,
		CFG_FRICTION    = 3'd5
	} cfg_reg_t;

	localparam uword_t RST_TIME_STEP   = uword_t'(1092);
	localparam uword_t RST_BAUMGARTE   = uword_t'(26214);
	localparam uword_t RST_POS_SLOP    = uword_t'(131072);
	localparam uword_t RST_RESTITUTION = uword_t'(0);
	localparam uword_t RST_VEL_SLOP    = uword_t'(327680);
	localparam uword_t RST_FRICTION    = uword_t'(32768);

	// Request types
	localparam logic REQ_BODY_A = 1'b0;
	localparam logic REQ_BODY_B = 1'b1;

	// Item payloads
	typedef struct packed {
		logic   req_type;
		word_t  normal_x;
		word_t  normal_y;
		word_t  center_x;
		word_t  center_y;
		word_t  contact_x;
		word_t  contact_y;
		word_t  vel_x;
		word_t  vel_y;
		word_t  ang_vel;
		uword_t inv_mass;
		uword_t inv_inertia;
	} cis_in_t;

	typedef struct packed {
		word_t impulse_x;
		word_t impulse_y;
		word_t ang_impulse_a;
		word_t ang_impulse_b;
		logic  degenerate;
	} cis_out_t;

	// ALU operations
	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_DIV   = 4'd3,
		OP_MAX0  = 4'd4,
		OP_GATE  = 4'd5,
		OP_CLAMP = 4'd6,
		OP_LEN   = 4'd7,
		OP_ZTEST = 4'd8
	} cis_op_t;

	typedef struct packed {
		logic    start;
		cis_op_t op;
		word_t   a;
		word_t   b;
	} alu_req_t;

	typedef struct packed {
		logic  done;
		logic  zero;
		word_t y;
	} alu_rsp_t;

	// Scratch memory and operand codes
	localparam int SCR_DEPTH = 32;
	localparam int SCR_AW    = $clog2(SCR_DEPTH);
	localparam int SRC_W     = SCR_AW + 1;
	typedef logic [SRC_W-1:0] src_t;

	// scratch slots
	localparam src_t S_R1X  = 6'd0;
	localparam src_t S_R1Y  = 6'd1;
	localparam src_t S_R2X  = 6'd2;
	localparam src_t S_R2Y  = 6'd3;
	localparam src_t S_UX   = 6'd4;
	localparam src_t S_UY   = 6'd5;
	localparam src_t S_C1   = 6'd6;
	localparam src_t S_C2   = 6'd7;
	localparam src_t S_REL  = 6'd8;
	localparam src_t S_D    = 6'd9;
	localparam src_t S_K    = 6'd10;
	localparam src_t S_T1   = 6'd11;
	localparam src_t S_T2   = 6'd12;
	localparam src_t S_T3   = 6'd13;
	localparam src_t S_T4   = 6'd14;
	localparam src_t S_S    = 6'd15;
	localparam src_t S_BIAS = 6'd16;
	localparam src_t S_F    = 6'd17;
	localparam src_t S_PNX  = 6'd18;
	localparam src_t S_PNY  = 6'd19;
	localparam src_t S_PX   = 6'd20;
	localparam src_t S_PY   = 6'd21;
	localparam src_t S_OA   = 6'd22;
	localparam src_t S_OB   = 6'd23;
	localparam src_t S_NIL  = 6'd24;
	// stored body A
	localparam src_t A_NX = 6'd32;
	localparam src_t A_NY = 6'd33;
	localparam src_t A_CX = 6'd34;
	localparam src_t A_CY = 6'd35;
	localparam src_t A_PX = 6'd36;
	localparam src_t A_PY = 6'd37;
	localparam src_t A_VX = 6'd38;
	localparam src_t A_VY = 6'd39;
	localparam src_t A_W  = 6'd40;
	localparam src_t A_M  = 6'd41;
	localparam src_t A_I  = 6'd42;
	// latched body B
	localparam src_t B_CX = 6'd45;
	localparam src_t B_CY = 6'd46;
	localparam src_t B_PX = 6'd47;
	localparam src_t B_PY = 6'd48;
	localparam src_t B_VX = 6'd49;
	localparam src_t B_VY = 6'd50;
	localparam src_t B_W  = 6'd51;
	localparam src_t B_M  = 6'd52;
	localparam src_t B_I  = 6'd53;
	// configuration and constant zero
	localparam src_t C_DT    = 6'd54;
	localparam src_t C_BAUM  = 6'd55;
	localparam src_t C_PSLOP = 6'd56;
	localparam src_t C_REST  = 6'd57;
	localparam src_t C_VSLOP = 6'd58;
	localparam src_t C_MU    = 6'd59;
	localparam src_t ZERO    = 6'd60;

	typedef struct packed {
		cis_op_t op;
		src_t    dst;
		src_t    a;
		src_t    b;
	} uop_t;

	// Solve program
	localparam int NUM_UOPS = 106;
	localparam int PC_W     = $clog2(NUM_UOPS);
	localparam logic [PC_W-1:0] LAST_PC = PC_W'(NUM_UOPS - 1);

	localparam uop_t PROG [NUM_UOPS] = '{
		// lever arms, time step check, normal direction
		'{OP_SUB,   S_R1X, A_PX,  A_CX},
		'{OP_SUB,   S_R1Y, A_PY,  A_CY},
		'{OP_SUB,   S_R2X, B_PX,  B_CX},
		'{OP_SUB,   S_R2Y, B_PY,  B_CY},
		'{OP_ZTEST, S_NIL, C_DT,  ZERO},
		'{OP_ADD,   S_UX,  A_NX,  ZERO},
		'{OP_ADD,   S_UY,  A_NY,  ZERO},
		// direction block (normal): c1, c2, rel, d, k
		'{OP_MUL,   S_T1,  S_UX,  S_R1Y},
		'{OP_MUL,   S_T2,  S_UY,  S_R1X},
		'{OP_SUB,   S_C1,  S_T1,  S_T2},
		'{OP_MUL,   S_T1,  S_UX,  S_R2Y},
		'{OP_MUL,   S_T2,  S_UY,  S_R2X},
		'{OP_SUB,   S_C2,  S_T1,  S_T2},
		'{OP_MUL,   S_T1,  S_UX,  B_VX},
		'{OP_MUL,   S_T2,  S_UY,  B_VY},
		'{OP_ADD,   S_T3,  S_T1,  S_T2},
		'{OP_MUL,   S_T1,  S_UX,  A_VX},
		'{OP_MUL,   S_T2,  S_UY,  A_VY},
		'{OP_ADD,   S_T4,  S_T1,  S_T2},
		'{OP_SUB,   S_REL, S_T3,  S_T4},
		'{OP_MUL,   S_T1,  S_C1,  A_W},
		'{OP_ADD,   S_REL, S_REL, S_T1},
		'{OP_MUL,   S_T1,  S_C2,  B_W},
		'{OP_SUB,   S_REL, S_REL, S_T1},
		'{OP_MUL,   S_T1,  S_UX,  S_UX},
		'{OP_MUL,   S_T2,  S_UY,  S_UY},
		'{OP_ADD,   S_D,   S_T1,  S_T2},
		'{OP_MUL,   S_T1,  A_M,   S_D},
		'{OP_MUL,   S_T2,  S_C1,  S_C1},
		'{OP_MUL,   S_T2,  A_I,   S_T2},
		'{OP_ADD,   S_T3,  S_T1,  S_T2},
		'{OP_MUL,   S_T1,  B_M,   S_D},
		'{OP_MUL,   S_T2,  S_C2,  S_C2},
		'{OP_MUL,   S_T2,  B_I,   S_T2},
		'{OP_ADD,   S_T4,  S_T1,  S_T2},
		'{OP_ADD,   S_K,   S_T3,  S_T4},
		'{OP_ZTEST, S_NIL, S_K,   ZERO},
		// penetration depth above slop
		'{OP_SUB,   S_T1,  A_PX,  B_PX},
		'{OP_SUB,   S_T2,  A_PY,  B_PY},
		'{OP_MUL,   S_T3,  S_T1,  S_UX},
		'{OP_MUL,   S_T4,  S_T2,  S_UY},
		'{OP_ADD,   S_T3,  S_T3,  S_T4},
		'{OP_SUB,   S_T3,  S_T3,  C_PSLOP},
		'{OP_MAX0,  S_T3,  S_T3,  ZERO},
		// bias: depth correction and restitution
		'{OP_MUL,   S_T3,  C_BAUM, S_T3},
		'{OP_DIV,   S_T3,  S_T3,  C_DT},
		'{OP_SUB,   S_BIAS, ZERO, S_T3},
		'{OP_SUB,   S_T4,  S_REL, C_VSLOP},
		'{OP_MAX0,  S_T4,  S_T4,  ZERO},
		'{OP_MUL,   S_T4,  C_REST, S_T4},
		'{OP_ADD,   S_BIAS, S_BIAS, S_T4},
		// normal impulse
		'{OP_ADD,   S_T1,  S_REL, S_BIAS},
		'{OP_SUB,   S_T1,  ZERO,  S_T1},
		'{OP_DIV,   S_T1,  S_T1,  S_K},
		'{OP_MAX0,  S_T1,  S_T1,  ZERO},
		'{OP_GATE,  S_S,   S_T1,  C_DT},
		'{OP_MUL,   S_PNX, S_UX,  S_S},
		'{OP_MUL,   S_PNY, S_UY,  S_S},
		// tangent direction (-ny, nx)
		'{OP_SUB,   S_UX,  ZERO,  A_NY},
		'{OP_ADD,   S_UY,  A_NX,  ZERO},
		// direction block (tangent)
		'{OP_MUL,   S_T1,  S_UX,  S_R1Y},
		'{OP_MUL,   S_T2,  S_UY,  S_R1X},
		'{OP_SUB,   S_C1,  S_T1,  S_T2},
		'{OP_MUL,   S_T1,  S_UX,  S_R2Y},
		'{OP_MUL,   S_T2,  S_UY,  S_R2X},
		'{OP_SUB,   S_C2,  S_T1,  S_T2},
		'{OP_MUL,   S_T1,  S_UX,  B_VX},
		'{OP_MUL,   S_T2,  S_UY,  B_VY},
		'{OP_ADD,   S_T3,  S_T1,  S_T2},
		'{OP_MUL,   S_T1,  S_UX,  A_VX},
		'{OP_MUL,   S_T2,  S_UY,  A_VY},
		'{OP_ADD,   S_T4,  S_T1,  S_T2},
		'{OP_SUB,   S_REL, S_T3,  S_T4},
		'{OP_MUL,   S_T1,  S_C1,  A_W},
		'{OP_ADD,   S_REL, S_REL, S_T1},
		'{OP_MUL,   S_T1,  S_C2,  B_W},
		'{OP_SUB,   S_REL, S_REL, S_T1},
		'{OP_MUL,   S_T1,  S_UX,  S_UX},
		'{OP_MUL,   S_T2,  S_UY,  S_UY},
		'{OP_ADD,   S_D,   S_T1,  S_T2},
		'{OP_MUL,   S_T1,  A_M,   S_D},
		'{OP_MUL,   S_T2,  S_C1,  S_C1},
		'{OP_MUL,   S_T2,  A_I,   S_T2},
		'{OP_ADD,   S_T3,  S_T1,  S_T2},
		'{OP_MUL,   S_T1,  B_M,   S_D},
		'{OP_MUL,   S_T2,  S_C2,  S_C2},
		'{OP_MUL,   S_T2,  B_I,   S_T2},
		'{OP_ADD,   S_T4,  S_T1,  S_T2},
		'{OP_ADD,   S_K,   S_T3,  S_T4},
		'{OP_ZTEST, S_NIL, S_K,   ZERO},
		// friction impulse and its bound
		'{OP_SUB,   S_T1,  ZERO,  S_REL},
		'{OP_DIV,   S_T1,  S_T1,  S_K},
		'{OP_GATE,  S_F,   S_T1,  C_DT},
		'{OP_LEN,   S_T2,  S_PNX, S_PNY},
		'{OP_MUL,   S_T2,  C_MU,  S_T2},
		'{OP_CLAMP, S_F,   S_F,   S_T2},
		// total impulse
		'{OP_MUL,   S_T1,  S_UX,  S_F},
		'{OP_ADD,   S_PX,  S_PNX, S_T1},
		'{OP_MUL,   S_T1,  S_UY,  S_F},
		'{OP_ADD,   S_PY,  S_PNY, S_T1},
		// angular impulses
		'{OP_MUL,   S_T1,  S_R1Y, S_PX},
		'{OP_MUL,   S_T2,  S_R1X, S_PY},
		'{OP_SUB,   S_OA,  S_T1,  S_T2},
		'{OP_MUL,   S_T1,  S_R2X, S_PY},
		'{OP_MUL,   S_T2,  S_R2Y, S_PX},
		'{OP_SUB,   S_OB,  S_T1,  S_T2}
	};

	// Sign and magnitude back to a saturated word
	function automatic word_t sat_mag(input logic neg, input logic [2*WORD_WIDTH-1:0] m);
		logic [2*WORD_WIDTH-1:0] lim;
		word_t                   res;
		lim = (2*WORD_WIDTH)'(VMAX);
		if (!neg) begin
			res = (m > lim) ? VMAX : word_t'(m[WORD_WIDTH-1:0]);
		end else if (m > lim + 1'b1) begin
			res = VMIN;
		end else begin
			res = word_t'(-m[WORD_WIDTH-1:0]);
		end
		return res;
	endfunction

	// Magnitude of a signed word
	function automatic logic [WORD_WIDTH-1:0] mag(input word_t a);
		return a[WORD_WIDTH-1] ? -a : a;
	endfunction

endpackage

// File: hdl/cis_ram.sv
// ----------------------------------------------------------------------------
// cis_ram: generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/cis_alu.sv
// ----------------------------------------------------------------------------
// cis_alu: shared saturating fixed-point arithmetic unit
// Add, subtract, clamp and tests give a registered result; multiply scales its
// registered product in the MUL state; restoring division one quotient bit a
// cycle; vector length by squares and a bitwise integer root.
// ----------------------------------------------------------------------------
module cis_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  cis_pkg::alu_req_t  req,
	output cis_pkg::alu_rsp_t  rsp
);

	localparam int W     = cis_pkg::WORD_WIDTH;
	localparam int F     = cis_pkg::FRAC_BITS;
	localparam int NUM_W = W + F;
	localparam int CNT_W = $clog2(NUM_W);

	typedef enum logic [5:0] {
		AS_IDLE = 6'b000001,
		AS_MUL  = 6'b000010,
		AS_DIV  = 6'b000100,
		AS_SQ1  = 6'b001000,
		AS_SQ2  = 6'b010000,
		AS_ROOT = 6'b100000
	} alu_state_t;

	alu_state_t          state_q;
	logic                done_q;
	logic                zero_q;
	cis_pkg::word_t      y_q;
	logic                neg_q;
	logic [2*W-1:0]      prod_q;
	logic [NUM_W-1:0]    num_q;
	logic [W-1:0]        rem_q;
	logic [W-1:0]        den_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [W-1:0]        sx_q;
	logic [W-1:0]        sy_q;
	logic                k_q;
	logic [2*W-1:0]      x_q;
	logic [2*W-1:0]      r_q;
	logic [2*W-1:0]      bit_q;

	logic [W-1:0]        mag_a;
	logic [W-1:0]        mag_b;
	logic                neg_ab;
	logic                len_k;
	logic signed [W:0]   sum_w;
	logic signed [W:0]   dif_w;
	cis_pkg::word_t      add_sat;
	cis_pkg::word_t      sub_sat;
	cis_pkg::word_t      neg_b;
	cis_pkg::word_t      simple_y;
	logic [W:0]          rem_sh;
	logic                div_ge;
	logic [W:0]          rem_sub;
	logic [NUM_W-1:0]    num_nx;
	logic [2*W-1:0]      r_plus;
	logic                root_ge;
	logic [2*W-1:0]      r_nx;
	logic [2*W-1:0]      root_lim;

	assign mag_a  = cis_pkg::mag(req.a);
	assign mag_b  = cis_pkg::mag(req.b);
	assign neg_ab = req.a[W-1] ^ req.b[W-1];
	assign len_k  = mag_a[W-1] | mag_b[W-1];

	// operations with no multi-cycle state
	assign sum_w   = {req.a[W-1], req.a} + {req.b[W-1], req.b};
	assign dif_w   = {req.a[W-1], req.a} - {req.b[W-1], req.b};
	assign add_sat = (sum_w[W] != sum_w[W-1]) ? (sum_w[W] ? cis_pkg::VMIN : cis_pkg::VMAX)
		: sum_w[W-1:0];
	assign sub_sat = (dif_w[W] != dif_w[W-1]) ? (dif_w[W] ? cis_pkg::VMIN : cis_pkg::VMAX)
		: dif_w[W-1:0];
	assign neg_b   = -req.b;

	always_comb begin
		case (req.op)
			cis_pkg::OP_ADD:   simple_y = add_sat;
			cis_pkg::OP_SUB:   simple_y = sub_sat;
			cis_pkg::OP_MAX0:  simple_y = req.a[W-1] ? '0 : req.a;
			cis_pkg::OP_GATE:  simple_y = (req.b != '0) ? req.a : '0;
			cis_pkg::OP_CLAMP: begin
				if (req.a > req.b) begin
					simple_y = req.b;
				end else if (req.a < neg_b) begin
					simple_y = neg_b;
				end else begin
					simple_y = req.a;
				end
			end
			default:           simple_y = req.a;
		endcase
	end

	// one restoring division step
	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign div_ge  = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign num_nx  = {num_q[NUM_W-2:0], div_ge};

	// one integer root step
	assign r_plus   = r_q + bit_q;
	assign root_ge  = x_q >= r_plus;
	assign r_nx     = root_ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);
	assign root_lim = (2*W)'(cis_pkg::VMAX) >> k_q;

	// sequencing of the multi-cycle operations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AS_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				AS_IDLE: begin
					if (req.start) begin
						case (req.op)
							cis_pkg::OP_MUL: state_q <= AS_MUL;
							cis_pkg::OP_DIV: begin
								if (mag_b == '0) begin
									done_q <= 1'b1;
								end else begin
									state_q <= AS_DIV;
								end
							end
							cis_pkg::OP_LEN: state_q <= AS_SQ1;
							default:         done_q  <= 1'b1;
						endcase
					end
				end
				AS_MUL: begin
					state_q <= AS_IDLE;
					done_q  <= 1'b1;
				end
				AS_DIV: begin
					if (cnt_q == '0) begin
						state_q <= AS_IDLE;
						done_q  <= 1'b1;
					end
				end
				AS_SQ1: state_q <= AS_SQ2;
				AS_SQ2: state_q <= AS_ROOT;
				AS_ROOT: begin
					if (bit_q[0]) begin
						state_q <= AS_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= AS_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			AS_IDLE: begin
				if (req.start) begin
					zero_q <= (req.a == '0);
					neg_q  <= neg_ab;
					y_q    <= simple_y;
					prod_q <= (2*W)'(mag_a) * (2*W)'(mag_b);
					num_q  <= {mag_a, {F{1'b0}}};
					rem_q  <= '0;
					den_q  <= mag_b;
					cnt_q  <= CNT_W'(NUM_W - 1);
					k_q    <= len_k;
					sx_q   <= len_k ? (mag_a >> 1) : mag_a;
					sy_q   <= len_k ? (mag_b >> 1) : mag_b;
					if (req.op == cis_pkg::OP_DIV) begin
						y_q <= '0;
					end
				end
			end
			AS_MUL: y_q <= cis_pkg::sat_mag(neg_q, prod_q >> F);
			AS_DIV: begin
				rem_q <= div_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
				num_q <= num_nx;
				cnt_q <= cnt_q - 1'b1;
				y_q   <= cis_pkg::sat_mag(neg_q, (2*W)'(num_nx));
			end
			AS_SQ1: prod_q <= (2*W)'(sx_q) * (2*W)'(sx_q);
			AS_SQ2: begin
				x_q   <= prod_q + (2*W)'(sy_q) * (2*W)'(sy_q);
				r_q   <= '0;
				bit_q <= (2*W)'(1) << (2*W - 2);
			end
			AS_ROOT: begin
				if (root_ge) begin
					x_q <= x_q - r_plus;
				end
				r_q   <= r_nx;
				bit_q <= bit_q >> 2;
				y_q   <= (r_nx > root_lim) ? cis_pkg::VMAX : cis_pkg::word_t'(r_nx << k_q);
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.zero = zero_q;
	assign rsp.y    = y_q;

endmodule

// File: hdl/contact_impulse_solver.sv
// ----------------------------------------------------------------------------
// contact_impulse_solver: 2D contact impulse with friction, one contact per
// pair of items
// An A item (req_type 0) stores body A and the normal; a B item solves.
// ----------------------------------------------------------------------------
// An A item is registered as it is accepted and busy stays low. A B item raises
// busy and runs a 106-step program through one shared arithmetic unit; each step
// reads the scratch memory in fetch, starts the unit in issue and writes back in
// wait, and the longest steps are the three 48-step divisions and the 32-step
// vector root. The result is on result for the single cycle that done is high,
// and busy falls with it; the receiver cannot hold it, so it must take it then.
// The user must make configuration writes only while busy is low; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module contact_impulse_solver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  cis_pkg::cis_in_t                   item,
	output logic                               busy,
	output logic                               done,
	output cis_pkg::cis_out_t                  result,
	input  logic                               cfg_we,
	input  logic [cis_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  cis_pkg::uword_t                    cfg_wdata
);

	localparam int W  = cis_pkg::WORD_WIDTH;
	localparam int AW = cis_pkg::SCR_AW;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_ISSUE = 4'b0100,
		ST_WAIT  = 4'b1000
	} seq_state_t;

	seq_state_t                 state_q;
	logic [cis_pkg::PC_W-1:0]   pc_q;
	logic                       degen_q;
	logic                       done_q;
	cis_pkg::cis_out_t          result_q;
	cis_pkg::cis_in_t           held_q;
	cis_pkg::cis_in_t           body_b_q;
	cis_pkg::uword_t            dt_q;
	cis_pkg::uword_t            baum_q;
	cis_pkg::uword_t            pslop_q;
	cis_pkg::uword_t            rest_q;
	cis_pkg::uword_t            vslop_q;
	cis_pkg::uword_t            mu_q;

	cis_pkg::uop_t              uop;
	logic [W-1:0]               ram_a;
	logic [W-1:0]               ram_b;
	cis_pkg::word_t             opnd_a;
	cis_pkg::word_t             opnd_b;
	cis_pkg::alu_req_t          alu_req;
	cis_pkg::alu_rsp_t          alu_rsp;
	logic                       wr_en;
	logic                       accept;

	assign uop    = cis_pkg::PROG[pc_q];
	assign accept = start && (state_q == ST_IDLE);
	assign wr_en  = (state_q == ST_WAIT) && alu_rsp.done;

	// operand select from registers (non-scratch codes)
	function automatic cis_pkg::word_t reg_opnd(input cis_pkg::src_t code,
		input cis_pkg::cis_in_t ha, input cis_pkg::cis_in_t hb,
		input cis_pkg::uword_t dt, input cis_pkg::uword_t baum,
		input cis_pkg::uword_t pslop, input cis_pkg::uword_t rest,
		input cis_pkg::uword_t vslop, input cis_pkg::uword_t mu);
		cis_pkg::word_t v;
		unique case (code)
			cis_pkg::A_NX:    v = ha.normal_x;
			cis_pkg::A_NY:    v = ha.normal_y;
			cis_pkg::A_CX:    v = ha.center_x;
			cis_pkg::A_CY:    v = ha.center_y;
			cis_pkg::A_PX:    v = ha.contact_x;
			cis_pkg::A_PY:    v = ha.contact_y;
			cis_pkg::A_VX:    v = ha.vel_x;
			cis_pkg::A_VY:    v = ha.vel_y;
			cis_pkg::A_W:     v = ha.ang_vel;
			cis_pkg::A_M:     v = {1'b0, ha.inv_mass};
			cis_pkg::A_I:     v = {1'b0, ha.inv_inertia};
			cis_pkg::B_CX:    v = hb.center_x;
			cis_pkg::B_CY:    v = hb.center_y;
			cis_pkg::B_PX:    v = hb.contact_x;
			cis_pkg::B_PY:    v = hb.contact_y;
			cis_pkg::B_VX:    v = hb.vel_x;
			cis_pkg::B_VY:    v = hb.vel_y;
			cis_pkg::B_W:     v = hb.ang_vel;
			cis_pkg::B_M:     v = {1'b0, hb.inv_mass};
			cis_pkg::B_I:     v = {1'b0, hb.inv_inertia};
			cis_pkg::C_DT:    v = {1'b0, dt};
			cis_pkg::C_BAUM:  v = {1'b0, baum};
			cis_pkg::C_PSLOP: v = {1'b0, pslop};
			cis_pkg::C_REST:  v = {1'b0, rest};
			cis_pkg::C_VSLOP: v = {1'b0, vslop};
			cis_pkg::C_MU:    v = {1'b0, mu};
			default:          v = '0;
		endcase
		return v;
	endfunction

	assign opnd_a = uop.a[AW] ? reg_opnd(uop.a, held_q, body_b_q, dt_q, baum_q, pslop_q,
		rest_q, vslop_q, mu_q) : cis_pkg::word_t'(ram_a);
	assign opnd_b = uop.b[AW] ? reg_opnd(uop.b, held_q, body_b_q, dt_q, baum_q, pslop_q,
		rest_q, vslop_q, mu_q) : cis_pkg::word_t'(ram_b);

	// scratch memory, one copy per read port
	cis_ram #(.WIDTH(W), .DEPTH(cis_pkg::SCR_DEPTH)) u_scr_a (
		.clk   (clk),
		.we    (wr_en),
		.waddr (uop.dst[AW-1:0]),
		.wdata (alu_rsp.y),
		.raddr (uop.a[AW-1:0]),
		.rdata (ram_a)
	);

	cis_ram #(.WIDTH(W), .DEPTH(cis_pkg::SCR_DEPTH)) u_scr_b (
		.clk   (clk),
		.we    (wr_en),
		.waddr (uop.dst[AW-1:0]),
		.wdata (alu_rsp.y),
		.raddr (uop.b[AW-1:0]),
		.rdata (ram_b)
	);

	// shared arithmetic unit
	assign alu_req.start = (state_q == ST_ISSUE);
	assign alu_req.op    = uop.op;
	assign alu_req.a     = opnd_a;
	assign alu_req.b     = opnd_b;

	cis_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= '0;
			degen_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.req_type == cis_pkg::REQ_BODY_B) begin
						state_q <= ST_FETCH;
						pc_q    <= '0;
						degen_q <= 1'b0;
					end
				end
				ST_FETCH: state_q <= ST_ISSUE;
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (alu_rsp.done) begin
						if (uop.op == cis_pkg::OP_ZTEST && alu_rsp.zero) begin
							degen_q <= 1'b1;
						end
						if (pc_q == cis_pkg::LAST_PC) begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= ST_FETCH;
							pc_q    <= pc_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stored body A (reset to the all-zero record)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (accept && item.req_type == cis_pkg::REQ_BODY_A) begin
			held_q <= item;
		end
	end

	// body B latch
	always_ff @(posedge clk) begin
		if (accept && item.req_type == cis_pkg::REQ_BODY_B) begin
			body_b_q <= item;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q    <= cis_pkg::RST_TIME_STEP;
			baum_q  <= cis_pkg::RST_BAUMGARTE;
			pslop_q <= cis_pkg::RST_POS_SLOP;
			rest_q  <= cis_pkg::RST_RESTITUTION;
			vslop_q <= cis_pkg::RST_VEL_SLOP;
			mu_q    <= cis_pkg::RST_FRICTION;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cis_pkg::CFG_TIME_STEP:   dt_q    <= cfg_wdata;
				cis_pkg::CFG_BAUMGARTE:   baum_q  <= cfg_wdata;
				cis_pkg::CFG_POS_SLOP:    pslop_q <= cfg_wdata;
				cis_pkg::CFG_RESTITUTION: rest_q  <= cfg_wdata;
				cis_pkg::CFG_VEL_SLOP:    vslop_q <= cfg_wdata;
				cis_pkg::CFG_FRICTION:    mu_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// result capture as the final values are written back
	always_ff @(posedge clk) begin
		if (wr_en) begin
			case (uop.dst)
				cis_pkg::S_PX: result_q.impulse_x     <= alu_rsp.y;
				cis_pkg::S_PY: result_q.impulse_y     <= alu_rsp.y;
				cis_pkg::S_OA: result_q.ang_impulse_a <= alu_rsp.y;
				cis_pkg::S_OB: result_q.ang_impulse_b <= alu_rsp.y;
				default: ;
			endcase
			if (pc_q == cis_pkg::LAST_PC) begin
				result_q.degenerate <= degen_q;
			end
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule
